FILE: rtl/sgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sgb_pkg;

    localparam int PIX_W  = 24;
    localparam int WIN_MAX = 9;
    localparam int COL_W  = 12;
    localparam int TAP_W  = 17;
    localparam int ACC_W  = 32;

    // configuration register indexes
    localparam logic [2:0] CFG_IMAGE_WIDTH = 3'd0;
    localparam logic [2:0] CFG_BLUR_RADIUS = 3'd1;
    localparam logic [2:0] CFG_TAP_0       = 3'd2;
    localparam logic [2:0] CFG_TAP_1       = 3'd3;
    localparam logic [2:0] CFG_TAP_2       = 3'd4;
    localparam logic [2:0] CFG_TAP_3       = 3'd5;
    localparam logic [2:0] CFG_TAP_4       = 3'd6;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [4:0][TAP_W-1:0] t_taps;

    // one queued job: everything the back end needs from the front
    typedef struct packed {
        logic                     drain;
        logic                     last;
        logic [2:0]               radius;
        logic [COL_W-1:0]         col;
        logic [3:0]               rows_seen;
        logic [2:0]               base;
        logic [WIN_MAX-1:0][PIX_W-1:0] win;
    } t_job;

    typedef enum logic [3:0] {
        B_IDLE,
        B_COL,
        B_HACC,
        B_HFIN,
        B_HRD,
        B_HWAIT,
        B_VH,
        B_VRD,
        B_VACC,
        B_OUT,
        B_WR
    } t_bstate;

endpackage
`default_nettype wire

FILE: rtl/sgb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sgb_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire                  i_action,
    input  wire                  i_start_of_frame,
    input  wire  [7:0]           i_red_in,
    input  wire  [7:0]           i_green_in,
    input  wire  [7:0]           i_blue_in,
    input  wire  [10:0]          i_image_width,
    input  wire  [2:0]           i_blur_radius,
    output logic                 o_job_valid,
    output sgb_pkg::t_job        o_job,
    input  wire                  i_job_pop
);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RING = 2 * MAX_RADIUS;
    localparam logic [12:0] MW13 = 13'(MAX_WIDTH);
    localparam logic [2:0]  MR3  = 3'(MAX_RADIUS);
    localparam logic [2:0]  RL3  = 3'(RING - 1);

    logic [CW-1:0] r_col, n_col;
    logic [3:0]    r_rows, n_rows;
    logic [2:0]    r_base, n_base;
    logic [sgb_pkg::WIN_MAX-1:0][sgb_pkg::PIX_W-1:0] r_win, n_win;

    sgb_pkg::t_job r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    logic          push;
    logic [CW-1:0] col0, wm1, c;
    logic [3:0]    rows0;
    logic [2:0]    base0, rad;
    logic [12:0]   w13;
    logic          last;
    sgb_pkg::t_pix pix;
    sgb_pkg::t_job job;

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_comb begin
        pix   = {i_red_in, i_green_in, i_blue_in};
        col0  = i_start_of_frame ? '0 : r_col;
        rows0 = i_start_of_frame ? '0 : r_rows;
        base0 = i_start_of_frame ? '0 : r_base;
        w13   = {2'b00, i_image_width};
        if (w13 == 13'd0) begin
            w13 = 13'd1;
        end
        if (w13 > MW13) begin
            w13 = MW13;
        end
        wm1  = CW'(w13 - 13'd1);
        c    = (col0 < wm1) ? col0 : wm1;
        last = (c == wm1);
        rad  = (i_blur_radius > MR3) ? MR3 : i_blur_radius;

        n_win = r_win;
        if (!i_action) begin
            if (c == '0) begin
                for (int k = 0; k < sgb_pkg::WIN_MAX; k++) begin
                    n_win[k] = pix;
                end
            end else begin
                for (int k = sgb_pkg::WIN_MAX - 1; k > 0; k--) begin
                    n_win[k] = r_win[k-1];
                end
                n_win[0] = pix;
            end
        end

        if (last) begin
            n_col  = '0;
            n_rows = (rows0 == 4'd15) ? rows0 : rows0 + 4'd1;
            n_base = (base0 == RL3) ? 3'd0 : base0 + 3'd1;
        end else begin
            n_col  = c + CW'(1);
            n_rows = rows0;
            n_base = base0;
        end

        job.drain     = i_action;
        job.last      = last;
        job.radius    = rad;
        job.col       = sgb_pkg::COL_W'(c);
        job.rows_seen = rows0;
        job.base      = base0;
        job.win       = n_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_rows <= '0;
            r_base <= '0;
            r_win  <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_col  <= n_col;
                r_rows <= n_rows;
                r_base <= n_base;
                r_win  <= n_win;
                r_wp   <= ~r_wp;
            end
            if (i_job_pop && o_job_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_job_pop && o_job_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= RL3) else $error("ring slot out of range");

endmodule
`default_nettype wire

FILE: rtl/sgb_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sgb_back #(
    parameter int MAX_WIDTH        = 1024,
    parameter int MAX_RADIUS       = 4,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_job_valid,
    input  sgb_pkg::t_job        i_job,
    output logic                 o_job_pop,
    input  sgb_pkg::t_taps       i_taps,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic [7:0]           o_red_out,
    output logic [7:0]           o_green_out,
    output logic [7:0]           o_blue_out,
    output logic                 o_burst_last
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RING  = 2 * MAX_RADIUS;
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] MW_A  = AW'(MAX_WIDTH);
    localparam logic [4:0]    RING5 = 5'(RING);
    localparam logic [2:0]    RL3   = 3'(RING - 1);

    function automatic logic [7:0] finish(input logic [sgb_pkg::ACC_W-1:0] s);
        logic [sgb_pkg::ACC_W-1:0] q;
        q = s >> WEIGHT_FRAC_BITS;
        return (q > 32'd255) ? 8'd255 : q[7:0];
    endfunction

    sgb_pkg::t_bstate r_state, n_state;
    sgb_pkg::t_job    r_job;
    logic [2:0]       r_m;
    logic [3:0]       r_t;
    logic [CW-1:0]    r_x;
    sgb_pkg::t_pix    r_h, r_rd;
    logic [sgb_pkg::ACC_W-1:0] r_acc [3];
    logic             r_out_valid, r_out_last;
    sgb_pkg::t_pix    r_out;

    sgb_pkg::t_pix    r_mem [DEPTH];

    logic             can_load, mem_re, mem_we, load_out, acc_en;
    logic [AW-1:0]    raddr, waddr;
    logic [3:0]       two_r, mr, idx, back;
    logic [2:0]       wi, slot, prev;
    logic [4:0]       tmp;
    logic [sgb_pkg::TAP_W-1:0] wgt;
    sgb_pkg::t_pix    samp;
    logic             rows_ok, done_col;

    assign can_load     = !r_out_valid || !i_out_stall;
    assign o_out_valid  = r_out_valid;
    assign o_red_out    = r_out[23:16];
    assign o_green_out  = r_out[15:8];
    assign o_blue_out   = r_out[7:0];
    assign o_burst_last = r_out_last;

    always_comb begin
        two_r    = {r_job.radius, 1'b0};
        mr       = {1'b0, r_m} + {1'b0, r_job.radius};
        idx      = (r_t > mr) ? 4'd0 : mr - r_t;
        wi       = (r_t >= {1'b0, r_job.radius}) ? 3'(r_t - {1'b0, r_job.radius})
                                                 : 3'({1'b0, r_job.radius} - r_t);
        wgt      = i_taps[wi];
        back     = (r_t < r_job.rows_seen) ? r_t : r_job.rows_seen;
        tmp      = {2'b00, r_job.base} + RING5 - {1'b0, back};
        if (tmp >= RING5) begin
            tmp = tmp - RING5;
        end
        slot     = tmp[2:0];
        prev     = (r_job.base == 3'd0) ? RL3 : r_job.base - 3'd1;
        rows_ok  = (r_job.rows_seen >= {1'b0, r_job.radius});
        done_col = (r_m == 3'd0) || !r_job.last;
        case (r_state)
            sgb_pkg::B_HACC: samp = r_job.win[idx];
            sgb_pkg::B_VH:   samp = r_h;
            default:         samp = r_rd;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sgb_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.radius == 3'd0) begin
                        n_state = i_job.drain ? sgb_pkg::B_IDLE : sgb_pkg::B_OUT;
                    end else begin
                        n_state = sgb_pkg::B_COL;
                    end
                end
            end
            sgb_pkg::B_COL: begin
                if (r_job.col < sgb_pkg::COL_W'(r_m)) begin
                    n_state = done_col ? sgb_pkg::B_IDLE : sgb_pkg::B_COL;
                end else begin
                    n_state = r_job.drain ? sgb_pkg::B_HRD : sgb_pkg::B_HACC;
                end
            end
            sgb_pkg::B_HACC:  n_state = (r_t == two_r) ? sgb_pkg::B_HFIN : sgb_pkg::B_HACC;
            sgb_pkg::B_HFIN:  n_state = rows_ok ? sgb_pkg::B_VH : sgb_pkg::B_WR;
            sgb_pkg::B_HRD:   n_state = sgb_pkg::B_HWAIT;
            sgb_pkg::B_HWAIT: n_state = rows_ok ? sgb_pkg::B_VH : sgb_pkg::B_WR;
            sgb_pkg::B_VH:    n_state = sgb_pkg::B_VRD;
            sgb_pkg::B_VRD:   n_state = sgb_pkg::B_VACC;
            sgb_pkg::B_VACC:  n_state = (r_t == two_r) ? sgb_pkg::B_OUT : sgb_pkg::B_VRD;
            sgb_pkg::B_OUT: begin
                if (can_load) begin
                    n_state = (r_job.radius == 3'd0) ? sgb_pkg::B_IDLE : sgb_pkg::B_WR;
                end
            end
            sgb_pkg::B_WR:    n_state = done_col ? sgb_pkg::B_IDLE : sgb_pkg::B_COL;
            default:          n_state = sgb_pkg::B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_job_pop = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        load_out  = 1'b0;
        acc_en    = 1'b0;
        raddr     = '0;
        waddr     = AW'(r_job.base) * MW_A + AW'(r_x);
        case (r_state)
            sgb_pkg::B_IDLE: o_job_pop = i_job_valid;
            sgb_pkg::B_HACC: acc_en = 1'b1;
            sgb_pkg::B_HRD: begin
                mem_re = 1'b1;
                raddr  = AW'(prev) * MW_A + AW'(r_x);
            end
            sgb_pkg::B_VH:   acc_en = 1'b1;
            sgb_pkg::B_VRD: begin
                mem_re = 1'b1;
                raddr  = AW'(slot) * MW_A + AW'(r_x);
            end
            sgb_pkg::B_VACC: acc_en = 1'b1;
            sgb_pkg::B_OUT:  load_out = can_load;
            sgb_pkg::B_WR:   mem_we = 1'b1;
            default: begin
                o_job_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sgb_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
            r_m   <= i_job.radius;
        end
        case (r_state)
            sgb_pkg::B_COL: begin
                r_t <= '0;
                r_x <= CW'(r_job.col - sgb_pkg::COL_W'(r_m));
                for (int ch = 0; ch < 3; ch++) begin
                    r_acc[ch] <= '0;
                end
                if (r_job.col < sgb_pkg::COL_W'(r_m)) begin
                    r_m <= r_m - 3'd1;
                end
            end
            sgb_pkg::B_HFIN: begin
                r_h <= {finish(r_acc[2]), finish(r_acc[1]), finish(r_acc[0])};
                r_t <= '0;
                for (int ch = 0; ch < 3; ch++) begin
                    r_acc[ch] <= '0;
                end
            end
            sgb_pkg::B_HWAIT: begin
                r_h <= r_rd;
                r_t <= '0;
                for (int ch = 0; ch < 3; ch++) begin
                    r_acc[ch] <= '0;
                end
            end
            sgb_pkg::B_WR: begin
                r_m <= r_m - 3'd1;
            end
            default: begin
                if (acc_en) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_acc[ch] <= r_acc[ch]
                            + sgb_pkg::ACC_W'(wgt) * sgb_pkg::ACC_W'(samp[ch*8 +: 8]);
                    end
                    if (r_t != two_r) begin
                        r_t <= r_t + 4'd1;
                    end
                end
            end
        endcase
        if (load_out) begin
            if (r_job.radius == 3'd0) begin
                r_out      <= r_job.win[0];
                r_out_last <= 1'b1;
            end else begin
                r_out      <= {finish(r_acc[2]), finish(r_acc[1]), finish(r_acc[0])};
                r_out_last <= done_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= r_h;
        end
        if (mem_re) begin
            r_rd <= r_mem[raddr];
        end
    end

    a_vacc_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sgb_pkg::B_VACC |-> $past(r_state) == sgb_pkg::B_VRD)
        else $error("accumulate without a row read");
    a_wr_nonzero_r: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sgb_pkg::B_WR |-> r_job.radius != 3'd0)
        else $error("ring write in pass-through mode");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !load_out)
        else $error("held result overwritten");

endmodule
`default_nettype wire

FILE: rtl/separable_gaussian_blur_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake                    | word
// ---------+------------------------------+------------------------------------------
// input    | i_in_valid  / o_in_stall     | action, start_of_frame, red, green, blue
// output   | o_out_valid / i_out_stall    | red, green, blue, burst_last
// config   | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// each result column runs a horizontal pass (a ring read of the previous row for a
// drain), vertical taps through the ring memory read port, one output and one
// write-back, or only the write-back until radius rows are seen; up to r+1 columns
// at a row end, columns left of the edge skipped. radius zero passes a pixel
// through; a stalled output holds the back end. synchronous active-low
// reset clears control state, not the ring memory; a two-entry job queue decouples.
module separable_gaussian_blur_unit #(
    parameter int MAX_WIDTH        = 1024,
    parameter int MAX_RADIUS       = 4,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_action,
    input  wire         i_start_of_frame,
    input  wire  [7:0]  i_red_in,
    input  wire  [7:0]  i_green_in,
    input  wire  [7:0]  i_blue_in,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic        o_burst_last,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [16:0] i_cfg_data
);
    // configuration registers
    logic [10:0]          r_image_width;
    logic [2:0]           r_blur_radius;
    sgb_pkg::t_taps       r_taps;

    // front to back job queue
    logic                 job_valid, job_pop;
    sgb_pkg::t_job        job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= 11'd1024;
            r_blur_radius <= 3'd2;
            r_taps[0]     <= 17'd26386;
            r_taps[1]     <= 17'd16004;
            r_taps[2]     <= 17'd3571;
            r_taps[3]     <= 17'd0;
            r_taps[4]     <= 17'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sgb_pkg::CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data[10:0];
                sgb_pkg::CFG_BLUR_RADIUS: r_blur_radius <= i_cfg_data[2:0];
                sgb_pkg::CFG_TAP_0:       r_taps[0] <= i_cfg_data;
                sgb_pkg::CFG_TAP_1:       r_taps[1] <= i_cfg_data;
                sgb_pkg::CFG_TAP_2:       r_taps[2] <= i_cfg_data;
                sgb_pkg::CFG_TAP_3:       r_taps[3] <= i_cfg_data;
                sgb_pkg::CFG_TAP_4:       r_taps[4] <= i_cfg_data;
                default: begin
                    // unused index, write dropped
                    r_blur_radius <= r_blur_radius;
                end
            endcase
        end
    end

    // front: window, column and row counters, job queue
    sgb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_start_of_frame (i_start_of_frame),
        .i_red_in         (i_red_in),
        .i_green_in       (i_green_in),
        .i_blue_in        (i_blue_in),
        .i_image_width    (r_image_width),
        .i_blur_radius    (r_blur_radius),
        .o_job_valid      (job_valid),
        .o_job            (job),
        .i_job_pop        (job_pop)
    );

    // back: horizontal and vertical passes, ring of filtered rows, output register
    sgb_back #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_RADIUS       (MAX_RADIUS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job        (job),
        .o_job_pop    (job_pop),
        .i_taps       (r_taps),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_burst_last (o_burst_last)
    );

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> job_valid) else $error("job taken from empty queue");
    a_radius_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid |-> job.radius <= 3'(MAX_RADIUS))
        else $error("queued radius not clamped");
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_valid && job.last) |-> job.col < sgb_pkg::COL_W'(MAX_WIDTH))
        else $error("row end column beyond maximum width");

endmodule
`default_nettype wire
